// ----- rtl/prescaled_pulse_sequencer_macros.svh -----
// Assertion shorthands used by the checker file.
// Every macro samples on aclk and stays quiet while aresetn is low.
`ifndef PRESCALED_PULSE_SEQUENCER_MACROS_SVH
`define PRESCALED_PULSE_SEQUENCER_MACROS_SVH

// Same-cycle implication
`define PPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pps assertion failed");

// Next-cycle implication
`define PPS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pps assertion failed");

`endif

// ----- rtl/pps_pkg.sv -----
package pps_pkg;

    // Widths of the item channels and register port
    localparam int CfgWidth   = 8;
    localparam int PaddrWidth = 5;
    localparam int PdataWidth = 32;
    localparam int TdataWidth = 8;

    // Bit positions in the input tdata
    localparam int InRestartBit = 0;

    // Bit positions in the result tdata
    localparam int OutStrobeBit  = 0;
    localparam int OutEnableBit  = 1;
    localparam int OutTriggerBit = 2;
    localparam int OutRunningBit = 3;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_PRESCALE_LIMIT  = 3'd0,
        REG_PERIOD_LENGTH   = 3'd1,
        REG_STROBE_LENGTH   = 3'd2,
        REG_ENABLE_DELAY    = 3'd3,
        REG_ENABLE_DURATION = 3'd4,
        REG_SAMPLE_INTERVAL = 3'd5,
        REG_PERIOD_COUNT    = 3'd6
    } reg_index_t;

    // Register reset values
    localparam logic [CfgWidth-1:0] RstPrescaleLimit  = 8'd5;
    localparam logic [CfgWidth-1:0] RstPeriodLength   = 8'd20;
    localparam logic [CfgWidth-1:0] RstStrobeLength   = 8'd3;
    localparam logic [CfgWidth-1:0] RstEnableDelay    = 8'd12;
    localparam logic [CfgWidth-1:0] RstEnableDuration = 8'd4;
    localparam logic [CfgWidth-1:0] RstSampleInterval = 8'd10;
    localparam logic [CfgWidth-1:0] RstPeriodCount    = 8'd3;

endpackage

// ----- rtl/prescaled_pulse_sequencer.sv -----
// An accepted tick's result is registered and appears on m_tdata in the next cycle.
// Throughput: one tick per cycle unless the result stalls; counter updates and compares
// are combinational, and the result register frees itself when downstream takes its item.
// Reset: aresetn is synchronous and active low; it clears all counters, output levels
// and the result valid, and loads the register defaults.
module prescaled_pulse_sequencer
    import pps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TdataWidth-1:0]  s_tdata,   // [0] restart, [7:1] zero
    // Result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TdataWidth-1:0]  m_tdata,   // [0] strobe_res, [1] converter_enable,
                                              // [2] sample_trigger, [3] running, [7:4] zero
    // Register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PaddrWidth-1:0]  paddr,
    input  logic [PdataWidth-1:0]  pwdata,
    output logic [PdataWidth-1:0]  prdata,
    output logic                   pready
);

    // Configuration registers
    logic [CfgWidth-1:0] prescale_limit_reg;
    logic [CfgWidth-1:0] period_length_reg;
    logic [CfgWidth-1:0] strobe_length_reg;
    logic [CfgWidth-1:0] enable_delay_reg;
    logic [CfgWidth-1:0] enable_duration_reg;
    logic [CfgWidth-1:0] sample_interval_reg;
    logic [CfgWidth-1:0] period_count_reg;

    // Sequencer state
    logic [CfgWidth-1:0] prescale_counter_reg, prescale_counter_next;
    logic [CfgWidth-1:0] period_position_reg,  period_position_next;
    logic [CfgWidth-1:0] periods_done_reg,     periods_done_next;
    logic [CfgWidth-1:0] sample_counter_reg,   sample_counter_next;
    logic                strobe_level_reg,     strobe_level_next;
    logic                enable_level_reg,     enable_level_next;

    // Result register
    logic                  m_tvalid_reg;
    logic [TdataWidth-1:0] m_tdata_reg, m_tdata_next;

    // Per-tick working values
    logic                restart;
    logic                in_accept;
    logic                cfg_write;
    reg_index_t          cfg_index;
    logic [CfgWidth-1:0] cfg_data;
    logic [CfgWidth-1:0] ps_cur, pp_cur, pd_cur, sc_cur;
    logic                sl_cur, el_cur;
    logic                run, trigger, step, wrap;
    logic [CfgWidth-1:0] pp_wrapped;
    logic [CfgWidth:0]   enable_end;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[PaddrWidth-1:2]);
    assign cfg_data  = pwdata[CfgWidth-1:0];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_limit_reg  <= RstPrescaleLimit;
            period_length_reg   <= RstPeriodLength;
            strobe_length_reg   <= RstStrobeLength;
            enable_delay_reg    <= RstEnableDelay;
            enable_duration_reg <= RstEnableDuration;
            sample_interval_reg <= RstSampleInterval;
            period_count_reg    <= RstPeriodCount;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_PRESCALE_LIMIT:  prescale_limit_reg  <= cfg_data;
                REG_PERIOD_LENGTH:   period_length_reg   <= cfg_data;
                REG_STROBE_LENGTH:   strobe_length_reg   <= cfg_data;
                REG_ENABLE_DELAY:    enable_delay_reg    <= cfg_data;
                REG_ENABLE_DURATION: enable_duration_reg <= cfg_data;
                REG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data;
                REG_PERIOD_COUNT:    period_count_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_PRESCALE_LIMIT:  prdata[CfgWidth-1:0] = prescale_limit_reg;
            REG_PERIOD_LENGTH:   prdata[CfgWidth-1:0] = period_length_reg;
            REG_STROBE_LENGTH:   prdata[CfgWidth-1:0] = strobe_length_reg;
            REG_ENABLE_DELAY:    prdata[CfgWidth-1:0] = enable_delay_reg;
            REG_ENABLE_DURATION: prdata[CfgWidth-1:0] = enable_duration_reg;
            REG_SAMPLE_INTERVAL: prdata[CfgWidth-1:0] = sample_interval_reg;
            REG_PERIOD_COUNT:    prdata[CfgWidth-1:0] = period_count_reg;
            default:             prdata = '0;
        endcase
    end

    // Take a tick whenever the result register is empty or being drained
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign restart   = s_tdata[InRestartBit];

    // Apply restart before the tick is processed
    assign ps_cur = restart ? '0 : prescale_counter_reg;
    assign pp_cur = restart ? '0 : period_position_reg;
    assign pd_cur = restart ? '0 : periods_done_reg;
    assign sc_cur = restart ? '0 : sample_counter_reg;
    assign sl_cur = restart ? 1'b0 : strobe_level_reg;
    assign el_cur = restart ? 1'b0 : enable_level_reg;

    // Run, sample and prescaler decisions
    assign run        = pd_cur < period_count_reg;
    assign trigger    = run && (sc_cur >= sample_interval_reg);
    assign step       = run && (ps_cur >= prescale_limit_reg);
    assign wrap       = pp_cur >= period_length_reg;
    assign pp_wrapped = wrap ? '0 : pp_cur;
    assign enable_end = {1'b0, enable_delay_reg} + {1'b0, enable_duration_reg};

    // Next state; later position matches override earlier ones
    always_comb begin
        sample_counter_next   = sc_cur;
        prescale_counter_next = ps_cur;
        period_position_next  = pp_cur;
        periods_done_next     = pd_cur;
        strobe_level_next     = sl_cur;
        enable_level_next     = el_cur;
        if (run) begin
            sample_counter_next   = trigger ? 8'd1 : sc_cur + 8'd1;
            prescale_counter_next = step ? 8'd1 : ps_cur + 8'd1;
        end
        if (step) begin
            if (wrap) begin
                strobe_level_next = 1'b1;
                enable_level_next = 1'b0;
                periods_done_next = pd_cur + 8'd1;
            end
            if (pp_wrapped == strobe_length_reg) begin
                strobe_level_next = 1'b0;
            end
            if (pp_wrapped == enable_delay_reg) begin
                enable_level_next = 1'b1;
            end
            if ({1'b0, pp_wrapped} == enable_end) begin
                enable_level_next = 1'b0;
            end
            period_position_next = pp_wrapped + 8'd1;
        end
    end

    // Pack the result item
    always_comb begin
        m_tdata_next                = '0;
        m_tdata_next[OutStrobeBit]  = strobe_level_next;
        m_tdata_next[OutEnableBit]  = enable_level_next;
        m_tdata_next[OutTriggerBit] = trigger;
        m_tdata_next[OutRunningBit] = run;
    end

    // Advance state on each accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_counter_reg <= '0;
            period_position_reg  <= '0;
            periods_done_reg     <= '0;
            sample_counter_reg   <= '0;
            strobe_level_reg     <= 1'b0;
            enable_level_reg     <= 1'b0;
        end else if (in_accept) begin
            prescale_counter_reg <= prescale_counter_next;
            period_position_reg  <= period_position_next;
            periods_done_reg     <= periods_done_next;
            sample_counter_reg   <= sample_counter_next;
            strobe_level_reg     <= strobe_level_next;
            enable_level_reg     <= enable_level_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/pps_checker.sv -----
`include "prescaled_pulse_sequencer_macros.svh"

module pps_checker
    import pps_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [TdataWidth-1:0] m_tdata,
    input logic                  pready
);

    // A stalled result holds its value
    `PPS_ASSERT_NXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Every accepted tick produces a result in the next cycle
    `PPS_ASSERT_NXT(a_accept_gives_result, s_tvalid && s_tready, m_tvalid)

    // A full result register that is not drained blocks new ticks
    `PPS_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)

    // A sample only fires on a tick that ran
    `PPS_ASSERT_NOW(a_trigger_needs_run, m_tvalid && m_tdata[OutTriggerBit],
                    m_tdata[OutRunningBit])

    // The register port never waits
    `PPS_ASSERT_NOW(a_pready_high, 1'b1, pready)

endmodule

bind prescaled_pulse_sequencer pps_checker u_pps_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
